>>> hw/rtl/cpu8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_pkg: shared types and operation codes of the execute stage
// Operation codes, flag bit positions and controller/datapath command types.
// ----------------------------------------------------------------------------
package cpu8_pkg;

    localparam int FuncW = 7;
    localparam int DataW = 8;
    localparam int AddrW = 16;

    localparam int FlC = 0;
    localparam int FlZ = 1;
    localparam int FlS = 2;
    localparam int FlV = 3;
    localparam int FlD = 4;

    localparam logic [FuncW-1:0] OP_STOP = 7'd1;
    localparam logic [FuncW-1:0] OP_LDA  = 7'd2;
    localparam logic [FuncW-1:0] OP_LDX  = 7'd3;
    localparam logic [FuncW-1:0] OP_LDY  = 7'd4;
    localparam logic [FuncW-1:0] OP_LDF  = 7'd5;
    localparam logic [FuncW-1:0] OP_STA  = 7'd6;
    localparam logic [FuncW-1:0] OP_STX  = 7'd7;
    localparam logic [FuncW-1:0] OP_STY  = 7'd8;
    localparam logic [FuncW-1:0] OP_TAX_A = 7'd9;
    localparam logic [FuncW-1:0] OP_TAY_A = 7'd10;
    localparam logic [FuncW-1:0] OP_TXA  = 7'd11;
    localparam logic [FuncW-1:0] OP_TXY  = 7'd12;
    localparam logic [FuncW-1:0] OP_TXSP = 7'd13;
    localparam logic [FuncW-1:0] OP_TXSS = 7'd14;
    localparam logic [FuncW-1:0] OP_TYA  = 7'd15;
    localparam logic [FuncW-1:0] OP_TYX  = 7'd16;
    localparam logic [FuncW-1:0] OP_TYDS = 7'd17;
    localparam logic [FuncW-1:0] OP_TYES = 7'd18;
    localparam logic [FuncW-1:0] OP_TSPX = 7'd19;
    localparam logic [FuncW-1:0] OP_TSSX = 7'd20;
    localparam logic [FuncW-1:0] OP_TDSY = 7'd21;
    localparam logic [FuncW-1:0] OP_TESY = 7'd22;
    localparam logic [FuncW-1:0] OP_INCA = 7'd23;
    localparam logic [FuncW-1:0] OP_INCX = 7'd24;
    localparam logic [FuncW-1:0] OP_INCY = 7'd25;
    localparam logic [FuncW-1:0] OP_INCM = 7'd26;
    localparam logic [FuncW-1:0] OP_DECA = 7'd27;
    localparam logic [FuncW-1:0] OP_DECX = 7'd28;
    localparam logic [FuncW-1:0] OP_DECY = 7'd29;
    localparam logic [FuncW-1:0] OP_DECM = 7'd30;
    localparam logic [FuncW-1:0] OP_ADC  = 7'd31;
    localparam logic [FuncW-1:0] OP_SBB  = 7'd32;
    localparam logic [FuncW-1:0] OP_MUL  = 7'd33;
    localparam logic [FuncW-1:0] OP_DIV  = 7'd34;
    localparam logic [FuncW-1:0] OP_MOD  = 7'd35;
    localparam logic [FuncW-1:0] OP_AND  = 7'd36;
    localparam logic [FuncW-1:0] OP_OR   = 7'd37;
    localparam logic [FuncW-1:0] OP_XOR  = 7'd38;
    localparam logic [FuncW-1:0] OP_SHLA = 7'd39;
    localparam logic [FuncW-1:0] OP_SHLM = 7'd40;
    localparam logic [FuncW-1:0] OP_SHRA = 7'd41;
    localparam logic [FuncW-1:0] OP_SHRM = 7'd42;
    localparam logic [FuncW-1:0] OP_ROLA = 7'd43;
    localparam logic [FuncW-1:0] OP_ROLM = 7'd44;
    localparam logic [FuncW-1:0] OP_RORA = 7'd45;
    localparam logic [FuncW-1:0] OP_RORM = 7'd46;
    localparam logic [FuncW-1:0] OP_CMPA = 7'd47;
    localparam logic [FuncW-1:0] OP_CMPX = 7'd48;
    localparam logic [FuncW-1:0] OP_CMPY = 7'd49;
    localparam logic [FuncW-1:0] OP_JMP  = 7'd50;
    localparam logic [FuncW-1:0] OP_JC   = 7'd51;
    localparam logic [FuncW-1:0] OP_JNC  = 7'd52;
    localparam logic [FuncW-1:0] OP_JE   = 7'd53;
    localparam logic [FuncW-1:0] OP_JNE  = 7'd54;
    localparam logic [FuncW-1:0] OP_JS   = 7'd55;
    localparam logic [FuncW-1:0] OP_JNS  = 7'd56;
    localparam logic [FuncW-1:0] OP_JO   = 7'd57;
    localparam logic [FuncW-1:0] OP_JNO  = 7'd58;
    localparam logic [FuncW-1:0] OP_JA   = 7'd59;
    localparam logic [FuncW-1:0] OP_JNA  = 7'd60;
    localparam logic [FuncW-1:0] OP_JL   = 7'd61;
    localparam logic [FuncW-1:0] OP_JGE  = 7'd62;
    localparam logic [FuncW-1:0] OP_JG   = 7'd63;
    localparam logic [FuncW-1:0] OP_JNG  = 7'd64;
    localparam logic [FuncW-1:0] OP_LOOP = 7'd65;
    localparam logic [FuncW-1:0] OP_CLC  = 7'd67;
    localparam logic [FuncW-1:0] OP_CLZ  = 7'd68;
    localparam logic [FuncW-1:0] OP_CLS  = 7'd69;
    localparam logic [FuncW-1:0] OP_CLO  = 7'd70;
    localparam logic [FuncW-1:0] OP_CLD  = 7'd71;
    localparam logic [FuncW-1:0] OP_SEC  = 7'd72;
    localparam logic [FuncW-1:0] OP_SEZ  = 7'd73;
    localparam logic [FuncW-1:0] OP_SES  = 7'd74;
    localparam logic [FuncW-1:0] OP_SEO  = 7'd75;
    localparam logic [FuncW-1:0] OP_SED  = 7'd76;

    localparam int DivStepW = $clog2(DataW + 1);

    typedef struct packed {
        logic exec;      // run non-divider operation from latched request
        logic div_start; // load divider
        logic div_step;  // one restoring step
        logic div_done;  // commit divider result
    } t_cmd;

    typedef struct packed {
        logic is_div;    // latched request is divide or modulo with live run bit
        logic div_last;  // final divider step this cycle
    } t_sts;

endpackage

>>> hw/rtl/cpu8_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_datapath: register file, ALU and iterative divider
// Holds architectural state and the result register; acts on controller commands.
// ----------------------------------------------------------------------------
module cpu8_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [cpu8_pkg::FuncW-1:0]    i_func,
    input  logic [cpu8_pkg::DataW-1:0]    i_operand,
    input  logic [cpu8_pkg::AddrW-1:0]    i_location,
    input  logic [cpu8_pkg::DataW-1:0]    i_mem_value,
    input  cpu8_pkg::t_cmd                i_cmd,
    output cpu8_pkg::t_sts                o_sts,
    output logic                          o_mem_write,
    output logic [cpu8_pkg::DataW-1:0]    o_mem_data,
    output logic                          o_pc_load,
    output logic [cpu8_pkg::AddrW-1:0]    o_pc_target,
    output logic [cpu8_pkg::DataW-1:0]    o_acc_out,
    output logic [cpu8_pkg::DataW-1:0]    o_xreg_out,
    output logic [cpu8_pkg::DataW-1:0]    o_yreg_out,
    output logic [cpu8_pkg::DataW-1:0]    o_flags_out,
    output logic                          o_halted
);
    import cpu8_pkg::*;

    logic [FuncW-1:0] r_func;
    logic [DataW-1:0] r_opd, r_mv;
    logic [AddrW-1:0] r_loc;
    logic [DataW-1:0] r_acc, r_x, r_y, r_sp, r_ss, r_ds, r_es, r_fl;
    logic             r_run;
    logic [DataW-1:0] r_quo, r_rem;
    logic [DivStepW-1:0] r_cnt;

    logic [DataW-1:0] n_acc, n_x, n_y, n_sp, n_ss, n_ds, n_es, n_fl;
    logic             n_run, n_wr, n_jmp;
    logic [DataW-1:0] n_wd;
    logic             c, z, s, v, take;
    logic [DataW:0]   sum, dif;
    logic [2*DataW-1:0] prod;
    logic [DataW-1:0] zsv;
    logic             zs_en;
    logic [DataW:0]   rem_sh, rem_tr;

    assign c = r_fl[FlC];
    assign z = r_fl[FlZ];
    assign s = r_fl[FlS];
    assign v = r_fl[FlV];

    assign o_sts.is_div   = r_run && (r_func == OP_DIV || r_func == OP_MOD);
    assign o_sts.div_last = (r_cnt == DivStepW'(DataW - 1));

    assign rem_sh = {r_rem, r_quo[DataW-1]};
    assign rem_tr = rem_sh - {1'b0, r_opd};

    always_comb begin
        logic [DataW-1:0] a_in;
        a_in = r_acc;
        case (r_func)
            OP_CMPX: a_in = r_x;
            OP_CMPY: a_in = r_y;
            default: a_in = r_acc;
        endcase
        n_acc = r_acc; n_x = r_x; n_y = r_y; n_sp = r_sp; n_ss = r_ss;
        n_ds = r_ds; n_es = r_es; n_fl = r_fl; n_run = r_run;
        n_wr = 1'b0; n_wd = '0; take = 1'b0; zs_en = 1'b0; zsv = '0;
        sum  = {1'b0, r_acc} + {1'b0, r_opd} + {{DataW{1'b0}}, c};
        dif  = {1'b0, a_in} - {1'b0, r_opd}
             - {{DataW{1'b0}}, (r_func == OP_SBB) & c};
        prod = r_acc * r_opd;
        if (r_run) begin
            case (r_func)
                OP_STOP: n_run = 1'b0;
                OP_LDA:  begin n_acc = r_opd; zsv = r_opd; zs_en = 1'b1; end
                OP_LDX:  begin n_x = r_opd; zsv = r_opd; zs_en = 1'b1; end
                OP_LDY:  begin n_y = r_opd; zsv = r_opd; zs_en = 1'b1; end
                OP_LDF:  n_fl = r_opd;
                OP_STA:  begin n_wr = 1'b1; n_wd = r_acc; end
                OP_STX:  begin n_wr = 1'b1; n_wd = r_x; end
                OP_STY:  begin n_wr = 1'b1; n_wd = r_y; end
                OP_TAX_A: begin n_acc = r_x; zsv = r_x; zs_en = 1'b1; end
                OP_TAY_A: begin n_acc = r_y; zsv = r_y; zs_en = 1'b1; end
                OP_TXA:  begin n_x = r_acc; zsv = r_acc; zs_en = 1'b1; end
                OP_TXY:  begin n_x = r_y; zsv = r_y; zs_en = 1'b1; end
                OP_TXSP: begin n_x = r_sp; zsv = r_sp; zs_en = 1'b1; end
                OP_TXSS: begin n_x = r_ss; zsv = r_ss; zs_en = 1'b1; end
                OP_TYA:  begin n_y = r_acc; zsv = r_acc; zs_en = 1'b1; end
                OP_TYX:  begin n_y = r_x; zsv = r_x; zs_en = 1'b1; end
                OP_TYDS: begin n_y = r_ds; zsv = r_ds; zs_en = 1'b1; end
                OP_TYES: begin n_y = r_es; zsv = r_es; zs_en = 1'b1; end
                OP_TSPX: begin n_sp = r_x; zsv = r_x; zs_en = 1'b1; end
                OP_TSSX: begin n_ss = r_x; zsv = r_x; zs_en = 1'b1; end
                OP_TDSY: begin n_ds = r_y; zsv = r_y; zs_en = 1'b1; end
                OP_TESY: begin n_es = r_y; zsv = r_y; zs_en = 1'b1; end
                OP_INCA: begin n_acc = r_acc + 1'b1; zsv = n_acc; zs_en = 1'b1; end
                OP_INCX: begin n_x = r_x + 1'b1; zsv = n_x; zs_en = 1'b1; end
                OP_INCY: begin n_y = r_y + 1'b1; zsv = n_y; zs_en = 1'b1; end
                OP_INCM: begin
                    n_wr = 1'b1; n_wd = r_mv + 1'b1; zsv = n_wd; zs_en = 1'b1;
                end
                OP_DECA: begin n_acc = r_acc - 1'b1; zsv = n_acc; zs_en = 1'b1; end
                OP_DECX: begin n_x = r_x - 1'b1; zsv = n_x; zs_en = 1'b1; end
                OP_DECY: begin n_y = r_y - 1'b1; zsv = n_y; zs_en = 1'b1; end
                OP_DECM: begin
                    n_wr = 1'b1; n_wd = r_mv - 1'b1; zsv = n_wd; zs_en = 1'b1;
                end
                OP_ADC: begin
                    n_acc = sum[DataW-1:0]; zsv = n_acc; zs_en = 1'b1;
                    n_fl[FlC] = sum[DataW];
                    n_fl[FlV] = (r_acc[DataW-1] == r_opd[DataW-1])
                             && (sum[DataW-1] != r_acc[DataW-1]);
                end
                OP_SBB, OP_CMPA, OP_CMPX, OP_CMPY: begin
                    if (r_func == OP_SBB) n_acc = dif[DataW-1:0];
                    zsv = dif[DataW-1:0]; zs_en = 1'b1;
                    n_fl[FlC] = dif[DataW];
                    n_fl[FlV] = (a_in[DataW-1] != r_opd[DataW-1])
                             && (dif[DataW-1] != a_in[DataW-1]);
                end
                OP_MUL: begin
                    n_acc = prod[DataW-1:0]; zsv = n_acc; zs_en = 1'b1;
                    n_fl[FlC] = |prod[2*DataW-1:DataW];
                end
                OP_AND: begin n_acc = r_acc & r_opd; zsv = n_acc; zs_en = 1'b1; end
                OP_OR:  begin n_acc = r_acc | r_opd; zsv = n_acc; zs_en = 1'b1; end
                OP_XOR: begin n_acc = r_acc ^ r_opd; zsv = n_acc; zs_en = 1'b1; end
                OP_SHLA, OP_ROLA: begin
                    n_fl[FlC] = r_acc[DataW-1];
                    n_acc = {r_acc[DataW-2:0], (r_func == OP_ROLA) & c};
                    zsv = n_acc; zs_en = 1'b1;
                end
                OP_SHRA, OP_RORA: begin
                    n_fl[FlC] = r_acc[0];
                    n_acc = {(r_func == OP_RORA) & c, r_acc[DataW-1:1]};
                    zsv = n_acc; zs_en = 1'b1;
                end
                OP_SHLM, OP_ROLM: begin
                    n_fl[FlC] = r_mv[DataW-1]; n_wr = 1'b1;
                    n_wd = {r_mv[DataW-2:0], (r_func == OP_ROLM) & c};
                    zsv = n_wd; zs_en = 1'b1;
                end
                OP_SHRM, OP_RORM: begin
                    n_fl[FlC] = r_mv[0]; n_wr = 1'b1;
                    n_wd = {(r_func == OP_RORM) & c, r_mv[DataW-1:1]};
                    zsv = n_wd; zs_en = 1'b1;
                end
                OP_DIV: begin
                    n_acc = (r_opd == '0) ? '1 : r_quo; zsv = n_acc; zs_en = 1'b1;
                end
                OP_MOD: begin
                    n_acc = (r_opd == '0) ? r_acc : r_rem; zsv = n_acc; zs_en = 1'b1;
                end
                OP_JMP: take = 1'b1;
                OP_JC:  take = c;
                OP_JNC: take = !c;
                OP_JE:  take = z;
                OP_JNE: take = !z;
                OP_JS:  take = s;
                OP_JNS: take = !s;
                OP_JO:  take = v;
                OP_JNO: take = !v;
                OP_JA:  take = !c && !z;
                OP_JNA: take = c || z;
                OP_JL:  take = s != v;
                OP_JGE: take = s == v;
                OP_JG:  take = !z && (s == v);
                OP_JNG: take = z || (s != v);
                OP_LOOP: if (r_y != '0) begin n_y = r_y - 1'b1; take = 1'b1; end
                OP_CLC: n_fl[FlC] = 1'b0;
                OP_CLZ: n_fl[FlZ] = 1'b0;
                OP_CLS: n_fl[FlS] = 1'b0;
                OP_CLO: n_fl[FlV] = 1'b0;
                OP_CLD: n_fl[FlD] = 1'b0;
                OP_SEC: n_fl[FlC] = 1'b1;
                OP_SEZ: n_fl[FlZ] = 1'b1;
                OP_SES: n_fl[FlS] = 1'b1;
                OP_SEO: n_fl[FlV] = 1'b1;
                OP_SED: n_fl[FlD] = 1'b1;
                default: ;
            endcase
            if (zs_en) begin
                n_fl[FlZ] = (zsv == '0);
                n_fl[FlS] = zsv[DataW-1];
            end
        end
        n_jmp = take;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_func <= i_func; r_opd <= i_operand; r_loc <= i_location; r_mv <= i_mem_value;
        end
        if (i_cmd.div_start) begin
            r_quo <= r_acc; r_rem <= '0; r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
            if (!rem_tr[DataW]) begin
                r_rem <= rem_tr[DataW-1:0];
                r_quo <= {r_quo[DataW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DataW-1:0];
                r_quo <= {r_quo[DataW-2:0], 1'b0};
            end
        end
        if (!i_rst_n) begin
            r_acc <= '0; r_x <= '0; r_y <= '0; r_sp <= '0; r_ss <= '0;
            r_ds <= '0; r_es <= '0; r_fl <= '0; r_run <= 1'b1;
            o_mem_write <= 1'b0; o_mem_data <= '0; o_pc_load <= 1'b0; o_pc_target <= '0;
        end else if (i_cmd.exec || i_cmd.div_done) begin
            r_acc <= n_acc; r_x <= n_x; r_y <= n_y; r_sp <= n_sp; r_ss <= n_ss;
            r_ds <= n_ds; r_es <= n_es; r_fl <= n_fl; r_run <= n_run;
            o_mem_write <= n_wr;
            o_mem_data  <= n_wd;
            o_pc_load   <= n_jmp;
            o_pc_target <= n_jmp ? r_loc : '0;
        end
    end

    assign o_acc_out   = r_acc;
    assign o_xreg_out  = r_x;
    assign o_yreg_out  = r_y;
    assign o_flags_out = r_fl;
    assign o_halted    = !r_run;

endmodule

>>> hw/rtl/cpu8_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_ctrl: execute stage sequencer
// Takes requests, runs an exec step or the divider sequence, holds the result valid.
// ----------------------------------------------------------------------------
module cpu8_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_load,
    output cpu8_pkg::t_cmd o_cmd,
    input  cpu8_pkg::t_sts i_sts
);
    import cpu8_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_DECODE, S_DIV, S_DONE, S_OUT} t_state;
    t_state r_state, n_state;
    logic   r_valid, n_valid;

    assign o_ready = i_rst_n && ((r_state == S_IDLE) || (r_state == S_OUT && i_ready));
    assign o_load  = i_valid && o_ready;
    assign o_valid = r_valid;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_DECODE;
            S_DECODE: begin
                if (i_sts.is_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.div_done = 1'b1;
                n_valid = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: if (i_ready) begin
                n_valid = 1'b0;
                n_state = i_valid ? S_DECODE : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    a_valid_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid == (r_state == S_OUT)) else $error("valid out of step with state");
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_sts.div_last) |=> r_state == S_DONE)
        else $error("divider did not finish");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd)) else $error("conflicting commands");

endmodule

>>> hw/rtl/cpu8_execute_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_execute_unit: execute stage of an 8-bit accumulator CPU
// Applies one decoded operation per request and reports its effects.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries func, operand, location and the
//   memory byte at location. Output channel o_valid/i_ready carries one
//   result per request: memory write, jump decision and A, X, Y, flags and
//   the halted bit after the operation.
//   While running, divide and modulo pass through the 8-step restoring
//   divider loop; other operations are applied straight from decode.
//   No new request is taken while the previous one is still in flight.
//   A new request is taken in the cycle its predecessor's result is taken.
//   Reset clears A, X, Y, SP, SS, DS, ES and flags, sets the run bit, drops o_valid.
//   While the receiver stalls the result holds and no request is taken.
//   After stop every request is ignored but still answered.
// ----------------------------------------------------------------------------
module cpu8_execute_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [cpu8_pkg::FuncW-1:0]    i_func,
    input  logic [cpu8_pkg::DataW-1:0]    i_operand,
    input  logic [cpu8_pkg::AddrW-1:0]    i_location,
    input  logic [cpu8_pkg::DataW-1:0]    i_mem_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_mem_write,
    output logic [cpu8_pkg::DataW-1:0]    o_mem_data,
    output logic                          o_pc_load,
    output logic [cpu8_pkg::AddrW-1:0]    o_pc_target,
    output logic [cpu8_pkg::DataW-1:0]    o_acc_out,
    output logic [cpu8_pkg::DataW-1:0]    o_xreg_out,
    output logic [cpu8_pkg::DataW-1:0]    o_yreg_out,
    output logic [cpu8_pkg::DataW-1:0]    o_flags_out,
    output logic                          o_halted
);
    import cpu8_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic load;

    cpu8_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .o_load(load), .o_cmd(cmd), .i_sts(sts)
    );

    cpu8_datapath u_dp (
        .i_clk, .i_rst_n, .i_load(load), .i_func, .i_operand, .i_location,
        .i_mem_value, .i_cmd(cmd), .o_sts(sts), .o_mem_write, .o_mem_data,
        .o_pc_load, .o_pc_target, .o_acc_out, .o_xreg_out, .o_yreg_out,
        .o_flags_out, .o_halted
    );

endmodule
